// ----- design/vector3_normalize_assert.svh -----
// assertion macros for the vector normalizer
// used by vector3_normalize; expects clk and rst_n in scope
`ifndef VECTOR3_NORMALIZE_ASSERT_SVH
`define VECTOR3_NORMALIZE_ASSERT_SVH

// same-cycle implication
`define VN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/vn_pkg.sv -----
// shared types for the vector normalizer
// no dependencies
`timescale 1ns / 1ps

package vn_pkg;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
    logic nonzero;
  } vn_flags_t;

endpackage

// ----- design/vn_sqrt.sv -----
// pipelined integer square root, one root bit per stage
// depends on vn_pkg
`timescale 1ns / 1ps

module vn_sqrt #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                ce,
  input  logic [2*W-1:0]      sq_i,
  input  vn_pkg::vn_flags_t   flags_i,
  output logic [W-1:0]        root_o,
  output vn_pkg::vn_flags_t   flags_o
);

  logic [2*W-1:0]    rem_r   [W];
  logic [W-1:0]      root_r  [W];
  vn_pkg::vn_flags_t flags_r [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    localparam int K = W - 1 - i;
    logic [2*W-1:0]    rem_in;
    logic [W-1:0]      root_in;
    vn_pkg::vn_flags_t flags_in;
    logic [2*W:0]      trial;
    logic              take;
    logic [2*W-1:0]    rem_nxt;
    logic [W-1:0]      root_nxt;

    if (i == 0) begin : g_first
      assign rem_in   = sq_i;
      assign root_in  = '0;
      assign flags_in = flags_i;
    end else begin : g_next
      assign rem_in   = rem_r[i-1];
      assign root_in  = root_r[i-1];
      assign flags_in = flags_r[i-1];
    end

    // (root + 2^k)^2 - root^2 = root * 2^(k+1) + 2^(2k)
    assign trial = ({{(W+1){1'b0}}, root_in} << (K + 1))
                 | ({{(2*W){1'b0}}, 1'b1} << (2 * K));
    assign take  = {1'b0, rem_in} >= trial;
    always_comb begin
      rem_nxt  = rem_in;
      root_nxt = root_in;
      if (take) begin
        rem_nxt  = rem_in - trial[2*W-1:0];
        root_nxt = root_in | ({{(W-1){1'b0}}, 1'b1} << K);
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[i]   <= rem_nxt;
        root_r[i]  <= root_nxt;
        flags_r[i] <= flags_in;
      end
    end
  end

  assign root_o  = root_r[W-1];
  assign flags_o = flags_r[W-1];

endmodule

// ----- design/vn_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// computes (mag << fb) / len for mag <= len; no package use
`timescale 1ns / 1ps

module vn_div #(
  parameter int CW = 16,
  parameter int FB = 14
) (
  input  logic          clk,
  input  logic          ce,
  input  logic [CW-1:0] mag_i,
  input  logic [CW-1:0] len_i,
  output logic [FB:0]   quot_o,
  output logic [CW-1:0] len_o
);

  localparam int NS = FB + 1;

  logic [CW-1:0] rem_r  [NS];
  logic [FB:0]   quot_r [NS];
  logic [CW-1:0] len_r  [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [CW:0]   shifted;
    logic [FB:0]   quot_in;
    logic [CW-1:0] len_in;
    logic          take;
    logic [CW:0]   diff;

    if (j == 0) begin : g_first
      assign shifted = {1'b0, mag_i};
      assign quot_in = '0;
      assign len_in  = len_i;
    end else begin : g_next
      assign shifted = {rem_r[j-1], 1'b0};
      assign quot_in = quot_r[j-1];
      assign len_in  = len_r[j-1];
    end

    assign take = shifted >= {1'b0, len_in};
    assign diff = shifted - {1'b0, len_in};

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[j]  <= take ? diff[CW-1:0] : shifted[CW-1:0];
        quot_r[j] <= {quot_in[FB-1:0], take};
        len_r[j]  <= len_in;
      end
    end
  end

  assign quot_o = quot_r[NS-1];
  assign len_o  = len_r[NS-1];

endmodule

// ----- design/vector3_normalize.sv -----
// vector3_normalize: pipelined 3-D vector normalizer
// throughput one vector per cycle; the whole pipeline advances unless the output is stalled
// stages: abs, squares, sum, one root bit per stage, one quotient bit per stage, output
// rst_n is synchronous active low and clears the valid bits; no clearing pass
// depends on vn_pkg, vn_sqrt, vn_div and vector3_normalize_assert.svh
`timescale 1ns / 1ps

module vector3_normalize #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  logic clk,
  input  logic rst_n,
  // comp_x, comp_y, comp_z
  input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic in_tvalid,
  output logic in_tready,
  // unit_x, unit_y, unit_z, length
  output logic [((3*(FRACTION_BITS+2)+COMPONENT_WIDTH+7)/8)*8-1:0] out_tdata,
  // nonzero
  output logic [0:0] out_tuser,
  output logic out_tvalid,
  input  logic out_tready
);

  localparam int CW  = COMPONENT_WIDTH;
  localparam int FB  = FRACTION_BITS;
  localparam int UW  = FB + 2;
  localparam int OW  = ((3*UW+CW+7)/8)*8;
  localparam int LAT = CW + FB + 5;
  localparam int MD  = CW + 2;
  localparam int FD  = FB + 1;

  logic ce;
  logic [LAT-1:0] valid_r;

  assign ce         = !valid_r[LAT-1] || out_tready;
  assign in_tready  = ce;
  assign out_tvalid = valid_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ce) begin
      valid_r <= {valid_r[LAT-2:0], in_tvalid};
    end
  end

  // abs stage
  logic signed [CW-1:0] cx, cy, cz;
  logic [CW-1:0]        ax_r, ay_r, az_r;
  vn_pkg::vn_flags_t    fl0_r;

  assign cx = in_tdata[CW-1:0];
  assign cy = in_tdata[2*CW-1:CW];
  assign cz = in_tdata[3*CW-1:2*CW];

  always_ff @(posedge clk) begin
    if (ce) begin
      ax_r          <= cx[CW-1] ? -cx : cx;
      ay_r          <= cy[CW-1] ? -cy : cy;
      az_r          <= cz[CW-1] ? -cz : cz;
      fl0_r.neg_x   <= cx[CW-1];
      fl0_r.neg_y   <= cy[CW-1];
      fl0_r.neg_z   <= cz[CW-1];
      fl0_r.nonzero <= (cx != '0) || (cy != '0) || (cz != '0);
    end
  end

  // squares and sum
  logic [2*CW-1:0]   sqx_r, sqy_r, sqz_r, sum_r;
  vn_pkg::vn_flags_t fl1_r, fl2_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      sqx_r <= ax_r * ax_r;
      sqy_r <= ay_r * ay_r;
      sqz_r <= az_r * az_r;
      fl1_r <= fl0_r;
      sum_r <= sqx_r + sqy_r + sqz_r;
      fl2_r <= fl1_r;
    end
  end

  // magnitudes wait for the root
  logic [3*CW-1:0] mag_r [MD];

  always_ff @(posedge clk) begin
    if (ce) begin
      mag_r[0] <= {az_r, ay_r, ax_r};
      for (int m = 1; m < MD; m++) begin
        mag_r[m] <= mag_r[m-1];
      end
    end
  end

  logic [CW-1:0]     root;
  vn_pkg::vn_flags_t fl_root;

  vn_sqrt #(.W(CW)) u_sqrt (
    .clk     (clk),
    .ce      (ce),
    .sq_i    (sum_r),
    .flags_i (fl2_r),
    .root_o  (root),
    .flags_o (fl_root)
  );

  logic [FB:0]   qx, qy, qz;
  logic [CW-1:0] len_x, len_y, len_z;

  vn_div #(.CW(CW), .FB(FB)) u_div_x (
    .clk (clk), .ce (ce), .mag_i (mag_r[MD-1][CW-1:0]), .len_i (root),
    .quot_o (qx), .len_o (len_x)
  );

  vn_div #(.CW(CW), .FB(FB)) u_div_y (
    .clk (clk), .ce (ce), .mag_i (mag_r[MD-1][2*CW-1:CW]), .len_i (root),
    .quot_o (qy), .len_o (len_y)
  );

  vn_div #(.CW(CW), .FB(FB)) u_div_z (
    .clk (clk), .ce (ce), .mag_i (mag_r[MD-1][3*CW-1:2*CW]), .len_i (root),
    .quot_o (qz), .len_o (len_z)
  );

  vn_pkg::vn_flags_t fl_d_r [FD];

  always_ff @(posedge clk) begin
    if (ce) begin
      fl_d_r[0] <= fl_root;
      for (int m = 1; m < FD; m++) begin
        fl_d_r[m] <= fl_d_r[m-1];
      end
    end
  end

  // output stage
  vn_pkg::vn_flags_t fl_o;
  logic [UW-1:0] ux_r, uy_r, uz_r;
  logic [CW-1:0] len_r;
  logic          nz_r;
  logic [UW-1:0] ux_ext, uy_ext, uz_ext;

  assign fl_o   = fl_d_r[FD-1];
  assign ux_ext = {1'b0, qx};
  assign uy_ext = {1'b0, qy};
  assign uz_ext = {1'b0, qz};

  always_ff @(posedge clk) begin
    if (ce) begin
      nz_r  <= fl_o.nonzero;
      ux_r  <= !fl_o.nonzero ? '0 : (fl_o.neg_x ? -ux_ext : ux_ext);
      uy_r  <= !fl_o.nonzero ? '0 : (fl_o.neg_y ? -uy_ext : uy_ext);
      uz_r  <= !fl_o.nonzero ? '0 : (fl_o.neg_z ? -uz_ext : uz_ext);
      len_r <= !fl_o.nonzero ? '0 : (len_x & len_y & len_z);
    end
  end

  assign out_tdata = {{(OW-3*UW-CW){1'b0}}, len_r, uz_r, uy_r, ux_r};
  assign out_tuser = nz_r;

  logic signed [UW-1:0] sux;
  logic signed [UW-1:0] unit_one;
  logic                 ux_in_range;
  logic                 len_same;
  assign sux         = ux_r;
  assign unit_one    = {{(UW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
  assign ux_in_range = (sux <= unit_one) && (sux >= -unit_one);
  assign len_same    = (len_x == len_y) && (len_y == len_z);

  `include "vector3_normalize_assert.svh"

  `VN_ASSERT_NOW(a_zero_clean, out_tvalid && !out_tuser[0], out_tdata == '0, "zero beat dirty")
  `VN_ASSERT_NOW(a_len_nonzero, out_tvalid && out_tuser[0], len_r != '0, "zero length")
  `VN_ASSERT_NOW(a_unit_range, out_tvalid && out_tuser[0], ux_in_range, "unit x out of range")
  `VN_ASSERT_NOW(a_len_agree, valid_r[LAT-2] && fl_o.nonzero, len_same, "lane lengths differ")
  `VN_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stall lost")

endmodule

// ----- sim/vector3_normalize_test.sv -----
// testbench for vector3_normalize: random and directed vectors, checked against
// an in-bench fixed-point normalizer model; depends only on the vector3_normalize rtl
`timescale 1ns / 1ps

typedef struct {
  logic [15:0] ux;
  logic [15:0] uy;
  logic [15:0] uz;
  logic [15:0] len;
  logic        nz;
} unit_vec_t;

class unit_vec_board;
  unit_vec_t pending[$];
  int        errors;

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] unit_part(logic signed [15:0] c, logic [63:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (c < 0) ? 64'(-64'(c)) : 64'(c);
    q = (mag << 14) / len;
    if (c < 0) q = -q;
    return q[15:0];
  endfunction

  function void note_vector(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
    unit_vec_t e;
    logic [63:0] sum;
    logic [63:0] len;
    sum = 64'(longint'(x) * x) + 64'(longint'(y) * y) + 64'(longint'(z) * z);
    if (sum == 0) begin
      e = '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0};
    end else begin
      len = root_floor(sum);
      e.ux = unit_part(x, len);
      e.uy = unit_part(y, len);
      e.uz = unit_part(z, len);
      e.len = len[15:0];
      e.nz = 1'b1;
    end
    pending.push_back(e);
  endfunction

  task report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task check_result(logic [63:0] data, logic nz);
    unit_vec_t e;
    if (pending.size() == 0) begin
      report("unexpected beat", data[15:0], 16'd0);
      return;
    end
    e = pending.pop_front();
    if (data[15:0] !== e.ux) report("unit_x", data[15:0], e.ux);
    if (data[31:16] !== e.uy) report("unit_y", data[31:16], e.uy);
    if (data[47:32] !== e.uz) report("unit_z", data[47:32], e.uz);
    if (data[63:48] !== e.len) report("length", data[63:48], e.len);
    if (nz !== e.nz) report("nonzero", 16'(nz), 16'(e.nz));
  endtask
endclass

module vector3_normalize_test;
  logic        clk = 0;
  logic        rst_n = 0;
  logic [47:0] in_tdata = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready = 0;
  int          cycles = 0;
  int          stall_mode = 0;
  unit_vec_board board = new();

  vector3_normalize dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL vector3_normalize");
      $finish;
    end
  end

  // receiver stall pattern, changing its mood every so often
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser[0]);
    if (cycles % 200 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 1) != 0);
      default: out_tready <= ((cycles % 7) < 2);
    endcase
  end

  // hold one beat until accepted, valid stays high into the next beat
  task send_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    in_tdata <= {z, y, x};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_vector(x, y, z);
  endtask

  task pause(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      3: return 16'(int'($urandom_range(0, 511)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int burst;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_vector(16'h0000, 16'h0000, 16'h0000);
    send_vector(16'h8000, 16'h8000, 16'h8000);
    send_vector(16'h7fff, 16'h7fff, 16'h7fff);
    send_vector(16'h8000, 16'h0000, 16'h0000);
    send_vector(16'h0000, 16'h7fff, 16'h0000);
    send_vector(16'h0000, 16'h0000, 16'hffff);
    send_vector(16'h0001, 16'h0000, 16'h0000);
    send_vector(16'h0003, 16'h0004, 16'h0000);
    send_vector(16'hfffd, 16'h0000, 16'hfffc);
    send_vector(16'h0001, 16'h0001, 16'h0001);
    send_vector(16'h8000, 16'h7fff, 16'h0001);
    send_vector(16'h5555, 16'haaaa, 16'h0000);
    pause(1);
    while (board.pending.size() != 0) @(posedge clk);
    for (int i = 0; i < 600; i++) begin
      send_vector(pick_comp(), pick_comp(), pick_comp());
      burst = $urandom_range(0, 15);
      if (burst == 0) pause($urandom_range(1, 12));
      if (i == 300) begin
        pause(1);
        while (board.pending.size() != 0) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS vector3_normalize");
    end else begin
      $display("FAIL vector3_normalize");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+design
design/vn_pkg.sv
design/vn_sqrt.sv
design/vn_div.sv
design/vector3_normalize.sv
sim/vector3_normalize_test.sv
